// ===== rtl/core/snft_pkg.sv =====
// shared types and constants of the source nat flow table
package snft_pkg;

  // result status codes
  localparam logic [2:0] STATUS_HIT       = 3'd0;
  localparam logic [2:0] STATUS_NEW       = 3'd1;
  localparam logic [2:0] STATUS_MALFORMED = 3'd2;
  localparam logic [2:0] STATUS_NO_PORT   = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_IP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PORT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd4;

  // reset values
  localparam logic [31:0] RST_PUBLIC_IP  = 32'h0808_0808;
  localparam logic [15:0] RST_FIRST_PORT = 16'd1024;
  localparam logic [15:0] RST_PORT_LIMIT = 16'd65535;
  localparam logic [15:0] RST_MIN_LENGTH = 16'd54;
  localparam logic [15:0] RST_MAX_LENGTH = 16'd1500;

  // udp source and destination ports travel as l4_src and l4_dst
  typedef struct packed {
    logic [15:0] pkt_length;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_src_ip;
    logic [15:0] out_src_port;
    logic [31:0] flow_count;
  } out_t;

  // live configuration seen by the sequencer
  typedef struct packed {
    logic [31:0] public_ip;
    logic [15:0] port_limit;
    logic [15:0] min_length;
    logic [15:0] max_length;
  } cfg_t;

  // one flow table entry
  typedef struct packed {
    logic [31:0] key_src_ip;
    logic [31:0] key_dst_ip;
    logic [31:0] key_ports;
    logic [15:0] mapped_port;
    logic [31:0] packet_count;
  } entry_t;

endpackage

// ===== rtl/core/source_nat_flow_table.sv =====
// top level of the source nat flow table: config registers, output register, core
//
// Each beat on the input channel is one UDP packet's length and four-tuple;
// exactly one result beat comes back for it, in order. A packet whose length
// lies outside [min_length, max_length] changes nothing and its malformed
// result is registered from the check state once the output register is
// free. Otherwise the flow table memory is read one entry per cycle from
// entry 0 up to the current fill count and each entry is checked by a single
// key comparator: a hit ends the scan at that entry and a miss ends it after
// the last entry held, so the cost of one packet grows with the number of
// flows held, bounded by the one read port of the entry memory; a full
// output register stretches this until the result can be taken. The input is
// not ready while a packet is in work and is ready again from the cycle in
// which its result is registered; a finished result waits in the output
// register while the next packet is accepted. A hit rewrites the entry with
// a saturating packet count; a miss appends a new entry and hands out the
// next public port from a counter, unless the counter equals port_limit
// (ports exhausted) or the table is full. Entries are valid below the fill
// count, so reset needs no clearing pass. Writing first_port also reloads
// the port counter. Config writes are always ready and should be made while
// the block is idle; indexes past max_length are ignored.
module source_nat_flow_table #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  snft_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output snft_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [snft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                      cfg_data
);

  // address width of the entry memory and width of the fill count
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  snft_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             port_load;

  logic             out_valid_r;
  snft_pkg::out_t   out_data_r;
  logic             out_free;

  logic             seq_idle;
  logic             res_valid;
  snft_pkg::out_t   res;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  snft_pkg::entry_t rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  snft_pkg::entry_t wr_data;

  // config register decode
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt   = cfg_r;
    port_load = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        snft_pkg::CFG_PUBLIC_IP:  cfg_nxt.public_ip  = cfg_data;
        snft_pkg::CFG_FIRST_PORT: port_load          = 1'b1;
        snft_pkg::CFG_PORT_LIMIT: cfg_nxt.port_limit = cfg_data[15:0];
        snft_pkg::CFG_MIN_LENGTH: cfg_nxt.min_length = cfg_data[15:0];
        snft_pkg::CFG_MAX_LENGTH: cfg_nxt.max_length = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.public_ip  <= snft_pkg::RST_PUBLIC_IP;
      cfg_r.port_limit <= snft_pkg::RST_PORT_LIMIT;
      cfg_r.min_length <= snft_pkg::RST_MIN_LENGTH;
      cfg_r.max_length <= snft_pkg::RST_MAX_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input side: ready only while the sequencer is idle
  assign in_ready = seq_idle;

  // output register decouples the result from the next packet
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  snft_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW),
    .CW            (CW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .port_load       (port_load),
    .port_load_value (cfg_data[15:0]),
    .item_valid      (in_valid),
    .item            (in_data),
    .idle            (seq_idle),
    .out_free        (out_free),
    .res_valid       (res_valid),
    .res             (res),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

  snft_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

// ===== rtl/core/snft_mem.sv =====
// flow table entry memory, one write and one registered read port
module snft_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output snft_pkg::entry_t    rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  snft_pkg::entry_t    wr_data
);

  snft_pkg::entry_t mem_r [DEPTH];
  snft_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/snft_seq.sv =====
// lookup sequencer: scans entries through one key comparator, allocates on miss
module snft_seq #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int AW            = 10,
  parameter int CW            = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  snft_pkg::cfg_t     cfg,
  input  logic               port_load,
  input  logic [15:0]        port_load_value,
  input  logic               item_valid,
  input  snft_pkg::in_t      item,
  output logic               idle,
  input  logic               out_free,
  output logic               res_valid,
  output snft_pkg::out_t     res,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  snft_pkg::entry_t   rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output snft_pkg::entry_t   wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  snft_pkg::in_t    item_r;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [15:0]      next_port_r, next_port_nxt;

  logic             key_match;
  logic             scan_more;
  logic [31:0]      count_inc;

  // shared key comparator
  assign key_match = pend_r
                     && rd_data.key_src_ip == item_r.src_ip
                     && rd_data.key_dst_ip == item_r.dst_ip
                     && rd_data.key_ports  == {item_r.l4_src, item_r.l4_dst};
  assign scan_more = idx_r < used_r;
  assign count_inc = (rd_data.packet_count == '1) ? rd_data.packet_count
                                                  : rd_data.packet_count + 32'd1;
  assign idle      = state_r == S_IDLE;
  assign rd_addr   = idx_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    used_nxt      = used_r;
    next_port_nxt = next_port_r;
    res_valid     = 1'b0;
    res           = '0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (item_r.pkt_length > cfg.max_length || item_r.pkt_length < cfg.min_length) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res.status = snft_pkg::STATUS_MALFORMED;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        if (key_match) begin
          if (out_free) begin
            // hit: bump the saturating count in place
            wr_en                = 1'b1;
            wr_addr              = idx_r[AW-1:0] - AW'(1);
            wr_data.packet_count = count_inc;
            res_valid            = 1'b1;
            res.status           = snft_pkg::STATUS_HIT;
            res.out_src_ip       = cfg.public_ip;
            res.out_src_port     = rd_data.mapped_port;
            res.flow_count       = count_inc;
            state_nxt            = S_IDLE;
          end
        end else if (scan_more) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CW'(1);
        end else if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (next_port_r == cfg.port_limit) begin
            res.status = snft_pkg::STATUS_NO_PORT;
          end else if (used_r == CW'(TABLE_ENTRIES)) begin
            res.status = snft_pkg::STATUS_FULL;
          end else begin
            // miss: new entry at the fill count
            wr_en                = 1'b1;
            wr_addr              = used_r[AW-1:0];
            wr_data.key_src_ip   = item_r.src_ip;
            wr_data.key_dst_ip   = item_r.dst_ip;
            wr_data.key_ports    = {item_r.l4_src, item_r.l4_dst};
            wr_data.mapped_port  = next_port_r;
            wr_data.packet_count = 32'd1;
            res.status           = snft_pkg::STATUS_NEW;
            res.out_src_ip       = cfg.public_ip;
            res.out_src_port     = next_port_r;
            res.flow_count       = 32'd1;
            next_port_nxt        = next_port_r + 16'd1;
            used_nxt             = used_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (port_load) begin
      next_port_nxt = port_load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      used_r      <= '0;
      next_port_r <= snft_pkg::RST_FIRST_PORT;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      next_port_r <= next_port_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && item_valid) begin
      item_r <= item;
    end
  end

endmodule

// ===== rtl/core/snft_checker.sv =====
// port-level checks of the source nat flow table, bound to the top level
module snft_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input snft_pkg::out_t                   out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // failed lookups carry no translation
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == snft_pkg::STATUS_MALFORMED ||
                  out_data.status == snft_pkg::STATUS_NO_PORT ||
                  out_data.status == snft_pkg::STATUS_FULL)
    |-> out_data.out_src_ip == '0 && out_data.out_src_port == '0 &&
        out_data.flow_count == '0)
    else $error("failed lookup with nonzero translation");

  // a new flow starts counting at one
  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == snft_pkg::STATUS_NEW |-> out_data.flow_count == 32'd1)
    else $error("new flow count is not one");

  // the block takes one packet at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a packet beat");

endmodule

bind source_nat_flow_table snft_checker u_snft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the source nat flow table
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_ENTRIES = 1024;
  // a miss scans every entry held, so one packet may take the whole table
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 16;
  // far above the slowest correct run: every packet a full scan plus stalls
  localparam int CYCLE_LIMIT = 10_000_000;
  // index past the last register, the block must ignore writes to it
  localparam logic [snft_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  snft_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  snft_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [snft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  source_nat_flow_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // packets waiting to be driven, and translations waiting to come back
  snft_pkg::in_t packet_queue[$];
  snft_pkg::out_t xlat_queue[$];
  // four-tuples sent as flows so far, low indexes sit early in the table
  snft_pkg::in_t tuple_pool[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int beat_count = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------
  // translation predictor: its own copy of the registers and the flow table
  // ---------------------------------------------------------------------------
  logic [31:0] reg_public_ip;
  logic [15:0] reg_first_port;
  logic [15:0] reg_port_limit;
  logic [15:0] reg_min_len;
  logic [15:0] reg_max_len;
  logic [15:0] port_cursor;
  int tbl_used;
  logic [31:0] tbl_src_ip [TABLE_ENTRIES];
  logic [31:0] tbl_dst_ip [TABLE_ENTRIES];
  logic [31:0] tbl_ports [TABLE_ENTRIES];
  logic [15:0] tbl_pub_port [TABLE_ENTRIES];
  logic [31:0] tbl_hits [TABLE_ENTRIES];

  function automatic snft_pkg::out_t translate_packet(input snft_pkg::in_t p);
    snft_pkg::out_t r;
    int hit_idx;
    logic [31:0] ports;
    r = '0;
    hit_idx = -1;
    ports = {p.l4_src, p.l4_dst};
    if (p.pkt_length > reg_max_len || p.pkt_length < reg_min_len) begin
      r.status = snft_pkg::STATUS_MALFORMED;
    end else begin
      // exact match on all four fields, first valid entry wins
      for (int i = 0; i < tbl_used; i++) begin
        if (hit_idx < 0 && tbl_src_ip[i] == p.src_ip && tbl_dst_ip[i] == p.dst_ip &&
            tbl_ports[i] == ports)
          hit_idx = i;
      end
      if (hit_idx >= 0) begin
        // packet count saturates at all ones
        if (tbl_hits[hit_idx] != '1)
          tbl_hits[hit_idx] = tbl_hits[hit_idx] + 32'd1;
        r.status = snft_pkg::STATUS_HIT;
        r.out_src_port = tbl_pub_port[hit_idx];
        r.flow_count = tbl_hits[hit_idx];
      end else if (port_cursor == reg_port_limit) begin
        // port exhaustion takes priority over a full table
        r.status = snft_pkg::STATUS_NO_PORT;
      end else if (tbl_used >= TABLE_ENTRIES) begin
        r.status = snft_pkg::STATUS_FULL;
      end else begin
        tbl_src_ip[tbl_used] = p.src_ip;
        tbl_dst_ip[tbl_used] = p.dst_ip;
        tbl_ports[tbl_used] = ports;
        tbl_pub_port[tbl_used] = port_cursor;
        tbl_hits[tbl_used] = 32'd1;
        tbl_used = tbl_used + 1;
        r.status = snft_pkg::STATUS_NEW;
        r.out_src_port = port_cursor;
        r.flow_count = 32'd1;
        // 16-bit counter, wraps from 65535 to 0
        port_cursor = port_cursor + 16'd1;
      end
    end
    if (r.status == snft_pkg::STATUS_HIT || r.status == snft_pkg::STATUS_NEW)
      r.out_src_ip = reg_public_ip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // packet builders
  // ---------------------------------------------------------------------------
  function automatic snft_pkg::in_t pkt(input logic [15:0] len, input logic [31:0] sip,
                                        input logic [31:0] dip, input logic [15:0] sport,
                                        input logic [15:0] dport);
    snft_pkg::in_t p;
    p.pkt_length = len;
    p.src_ip = sip;
    p.dst_ip = dip;
    p.l4_src = sport;
    p.l4_dst = dport;
    return p;
  endfunction

  function automatic snft_pkg::in_t fresh_tuple(input logic [15:0] len);
    return pkt(len, $urandom, $urandom, 16'($urandom), 16'($urandom));
  endfunction

  // flip one bit of one key field, a near miss of an existing flow
  function automatic snft_pkg::in_t mutate_tuple(input snft_pkg::in_t base);
    snft_pkg::in_t m;
    m = base;
    case ($urandom_range(0, 3))
      0: m.src_ip = m.src_ip ^ (32'h1 << $urandom_range(0, 31));
      1: m.dst_ip = m.dst_ip ^ (32'h1 << $urandom_range(0, 31));
      2: m.l4_src = m.l4_src ^ (16'h1 << $urandom_range(0, 15));
      default: m.l4_dst = m.l4_dst ^ (16'h1 << $urandom_range(0, 15));
    endcase
    return m;
  endfunction

  // a length inside the window, or anything when the window is empty
  function automatic logic [15:0] fit_len();
    if (reg_min_len > reg_max_len)
      return 16'($urandom);
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? reg_min_len : reg_max_len;
    return 16'($urandom_range(int'(reg_max_len), int'(reg_min_len)));
  endfunction

  // a length outside the window where one exists
  function automatic logic [15:0] bad_len();
    logic exact;
    exact = ($urandom_range(0, 3) == 0);
    if (reg_min_len > reg_max_len || (reg_min_len == 16'd0 && reg_max_len == 16'hFFFF))
      return 16'($urandom);
    if (reg_min_len == 16'd0 || (reg_max_len != 16'hFFFF && $urandom_range(0, 1) == 1)) begin
      if (exact)
        return reg_max_len + 16'd1;
      return 16'($urandom_range(65535, int'(reg_max_len) + 1));
    end
    if (exact)
      return reg_min_len - 16'd1;
    return 16'($urandom_range(int'(reg_min_len) - 1, 0));
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR beat %0d: %s got 0x%0h expected 0x%0h", beat_count, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: pops the packet queue, predicts each beat as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_packets
    logic accepted;
    accepted = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (accepted)
        xlat_queue.push_back(translate_packet(in_data));
      // payload only changes once the current beat has gone
      if (!in_valid || accepted) begin
        if (packet_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= packet_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares every result beat with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    snft_pkg::out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beat_count = beat_count + 1;
        if (xlat_queue.size() == 0) begin
          report_mismatch("result beat with nothing pending, status", 32'(out_data.status),
                          32'h0);
        end else begin
          want = xlat_queue.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.out_src_ip !== want.out_src_ip)
            report_mismatch("out_src_ip", out_data.out_src_ip, want.out_src_ip);
          if (out_data.out_src_port !== want.out_src_port)
            report_mismatch("out_src_port", 32'(out_data.out_src_port),
                            32'(want.out_src_port));
          if (out_data.flow_count !== want.flow_count)
            report_mismatch("flow_count", out_data.flow_count, want.flow_count);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing helpers
  // ---------------------------------------------------------------------------
  // sampled on the falling edge so every nonblocking update has settled
  task automatic drain_packets();
    do @(negedge clk);
    while (packet_queue.size() != 0 || in_valid || xlat_queue.size() != 0);
  endtask

  // one register write beat, mirrored into the predictor once accepted
  task automatic write_reg(input logic [snft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      snft_pkg::CFG_PUBLIC_IP:  reg_public_ip = value;
      snft_pkg::CFG_FIRST_PORT: begin
        reg_first_port = value[15:0];
        port_cursor = value[15:0];
      end
      snft_pkg::CFG_PORT_LIMIT: reg_port_limit = value[15:0];
      snft_pkg::CFG_MIN_LENGTH: reg_min_len = value[15:0];
      snft_pkg::CFG_MAX_LENGTH: reg_max_len = value[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // mostly well-formed traffic: repeats of known flows (biased to early
  // entries so scans stay short), new flows and near misses, then some
  // malformed lengths and fully random noise
  task automatic gen_traffic(input int n);
    snft_pkg::in_t p;
    int roll;
    int hot;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      hot = (tuple_pool.size() < 40) ? tuple_pool.size() : 40;
      if (roll < 55 && hot > 0) begin
        if ($urandom_range(0, 99) < 85)
          p = tuple_pool[$urandom_range(0, hot - 1)];
        else
          p = tuple_pool[$urandom_range(0, tuple_pool.size() - 1)];
        p.pkt_length = fit_len();
      end else if (roll < 78) begin
        if (hot > 0 && $urandom_range(0, 99) < 30)
          p = mutate_tuple(tuple_pool[$urandom_range(0, tuple_pool.size() - 1)]);
        else
          p = fresh_tuple(16'h0);
        p.pkt_length = fit_len();
        tuple_pool.push_back(p);
      end else if (roll < 92) begin
        p = (hot > 0) ? tuple_pool[$urandom_range(0, hot - 1)] : fresh_tuple(16'h0);
        p.pkt_length = bad_len();
      end else begin
        p = fresh_tuple(16'($urandom));
      end
      packet_queue.push_back(p);
    end
  endtask

  task automatic push_fresh(input int n);
    snft_pkg::in_t p;
    repeat (n) begin
      p = fresh_tuple(fit_len());
      tuple_pool.push_back(p);
      packet_queue.push_back(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : run_test
    snft_pkg::in_t zero_key;
    snft_pkg::in_t ones_key;
    snft_pkg::in_t base_key;
    snft_pkg::in_t p;

    reg_public_ip = snft_pkg::RST_PUBLIC_IP;
    reg_first_port = snft_pkg::RST_FIRST_PORT;
    reg_port_limit = snft_pkg::RST_PORT_LIMIT;
    reg_min_len = snft_pkg::RST_MIN_LENGTH;
    reg_max_len = snft_pkg::RST_MAX_LENGTH;
    port_cursor = snft_pkg::RST_FIRST_PORT;
    tbl_used = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under reset configuration: window edges, all-zero and
    // all-one tuples, and near misses in a single key field or with swapped ports
    zero_key = pkt(16'd54, 32'h0, 32'h0, 16'h0, 16'h0);
    ones_key = pkt(16'd54, '1, '1, '1, '1);
    base_key = fresh_tuple(16'd600);
    packet_queue.push_back(pkt(16'd53, 32'h0, 32'h0, 16'h0, 16'h0));
    packet_queue.push_back(zero_key);
    packet_queue.push_back(pkt(16'd1500, 32'h0, 32'h0, 16'h0, 16'h0));
    packet_queue.push_back(pkt(16'd1501, 32'h0, 32'h0, 16'h0, 16'h0));
    packet_queue.push_back(pkt(16'd0, '1, '1, '1, '1));
    packet_queue.push_back(pkt(16'hFFFF, '1, '1, '1, '1));
    packet_queue.push_back(ones_key);
    packet_queue.push_back(pkt(16'd1000, '1, '1, '1, '1));
    tuple_pool.push_back(zero_key);
    tuple_pool.push_back(ones_key);
    tuple_pool.push_back(base_key);
    packet_queue.push_back(base_key);
    for (int f = 0; f < 5; f++) begin
      p = base_key;
      case (f)
        0: p.src_ip = p.src_ip ^ 32'h1;
        1: p.dst_ip = p.dst_ip ^ 32'h8000_0000;
        2: p.l4_src = p.l4_src ^ 16'h1;
        3: p.l4_dst = p.l4_dst ^ 16'h8000;
        default: begin
          // same ports, swapped between source and destination
          p.l4_src = base_key.l4_dst;
          p.l4_dst = base_key.l4_src;
        end
      endcase
      tuple_pool.push_back(p);
      packet_queue.push_back(p);
    end
    packet_queue.push_back(base_key);
    packet_queue.push_back(zero_key);
    drain_packets();

    // empty length window: everything is malformed
    write_reg(snft_pkg::CFG_MIN_LENGTH, 32'd100);
    write_reg(snft_pkg::CFG_MAX_LENGTH, 32'd99);
    packet_queue.push_back(pkt(16'd99, 32'h0, 32'h0, 16'h0, 16'h0));
    packet_queue.push_back(pkt(16'd100, 32'h0, 32'h0, 16'h0, 16'h0));
    drain_packets();
    // single-length window at the top of the range
    write_reg(snft_pkg::CFG_MAX_LENGTH, 32'hFFFF);
    write_reg(snft_pkg::CFG_MIN_LENGTH, 32'hFFFF);
    packet_queue.push_back(pkt(16'hFFFF, 32'h0, 32'h0, 16'h0, 16'h0));
    packet_queue.push_back(pkt(16'hFFFE, 32'h0, 32'h0, 16'h0, 16'h0));
    drain_packets();
    // single-length window at zero, plus a write to an unused index
    write_reg(snft_pkg::CFG_MIN_LENGTH, 32'd0);
    write_reg(snft_pkg::CFG_MAX_LENGTH, 32'd0);
    write_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
    packet_queue.push_back(pkt(16'd0, '1, '1, '1, '1));
    packet_queue.push_back(pkt(16'd1, '1, '1, '1, '1));
    drain_packets();

    // random phase, no idling on either side
    write_reg(snft_pkg::CFG_PUBLIC_IP, $urandom);
    write_reg(snft_pkg::CFG_MIN_LENGTH, 32'(snft_pkg::RST_MIN_LENGTH));
    write_reg(snft_pkg::CFG_MAX_LENGTH, 32'(snft_pkg::RST_MAX_LENGTH));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    gen_traffic(250);
    drain_packets();

    // widest window, sender idles
    write_reg(snft_pkg::CFG_PUBLIC_IP, 32'hFFFF_FFFF);
    write_reg(snft_pkg::CFG_MAX_LENGTH, 32'hFFFF);
    write_reg(snft_pkg::CFG_MIN_LENGTH, 32'd0);
    send_idle_pct = 59;
    recv_stall_pct = 0;
    gen_traffic(250);
    drain_packets();

    // narrow window, new port base, receiver stalls
    write_reg(snft_pkg::CFG_PUBLIC_IP, 32'h0);
    write_reg(snft_pkg::CFG_MIN_LENGTH, $urandom_range(20, 200));
    write_reg(snft_pkg::CFG_MAX_LENGTH, $urandom_range(300, 2000));
    write_reg(snft_pkg::CFG_FIRST_PORT, $urandom_range(1, 60000));
    send_idle_pct = 0;
    recv_stall_pct = 59;
    gen_traffic(250);
    drain_packets();

    // both sides idle; the sender holds off halfway until all results are back
    write_reg(snft_pkg::CFG_PUBLIC_IP, $urandom);
    write_reg(snft_pkg::CFG_MIN_LENGTH, $urandom_range(0, 64));
    write_reg(snft_pkg::CFG_MAX_LENGTH, $urandom_range(64, 9000));
    write_reg(snft_pkg::CFG_PORT_LIMIT, $urandom);
    send_idle_pct = 29;
    recv_stall_pct = 29;
    gen_traffic(120);
    drain_packets();
    gen_traffic(130);
    drain_packets();

    // ports exhausted while the table still has room: known flows still hit
    write_reg(snft_pkg::CFG_PORT_LIMIT, 32'(port_cursor));
    push_fresh(3);
    p = tuple_pool[2];
    p.pkt_length = fit_len();
    packet_queue.push_back(p);
    p.pkt_length = bad_len();
    packet_queue.push_back(p);
    drain_packets();

    // port counter wraps from 65535 to 0, then stops at the limit
    write_reg(snft_pkg::CFG_FIRST_PORT, 32'hFFFF);
    write_reg(snft_pkg::CFG_PORT_LIMIT, 32'd2);
    push_fresh(4);
    drain_packets();

    // zero port base with zero limit: no allocation at all
    write_reg(snft_pkg::CFG_FIRST_PORT, 32'd0);
    write_reg(snft_pkg::CFG_PORT_LIMIT, 32'd0);
    push_fresh(2);
    p = tuple_pool[0];
    p.pkt_length = fit_len();
    packet_queue.push_back(p);
    drain_packets();

    // fill every remaining entry; the limit sits below the port range used
    write_reg(snft_pkg::CFG_PUBLIC_IP, $urandom);
    write_reg(snft_pkg::CFG_MIN_LENGTH, 32'(snft_pkg::RST_MIN_LENGTH));
    write_reg(snft_pkg::CFG_MAX_LENGTH, 32'(snft_pkg::RST_MAX_LENGTH));
    write_reg(snft_pkg::CFG_FIRST_PORT, 32'd2000);
    write_reg(snft_pkg::CFG_PORT_LIMIT, 32'd1000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_fresh(TABLE_ENTRIES - tbl_used);
    drain_packets();

    // full table: misses fail, hits on the first two entries and the last one still work
    send_idle_pct = 29;
    recv_stall_pct = 29;
    push_fresh(5);
    for (int k = 0; k < 2; k++) begin
      p = tuple_pool[k];
      p.pkt_length = fit_len();
      packet_queue.push_back(p);
    end
    p = tuple_pool[tuple_pool.size() - 6];
    p.pkt_length = fit_len();
    packet_queue.push_back(p);
    p.pkt_length = bad_len();
    packet_queue.push_back(p);
    drain_packets();

    // full table and ports exhausted together
    write_reg(snft_pkg::CFG_PORT_LIMIT, 32'(port_cursor));
    push_fresh(3);
    p = tuple_pool[3];
    p.pkt_length = fit_len();
    packet_queue.push_back(p);
    p.pkt_length = bad_len();
    packet_queue.push_back(p);
    drain_packets();

    // catch any stray result beat after the last one expected
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
